>>> hdl/gmd_pkg.sv
// ----------------------------------------------------------------------------
// gmd_pkg: shared types and constants for the gradient magnitude/direction unit
// Payload structs, field widths, configuration reset value and tan(pi/8) split.
// ----------------------------------------------------------------------------
package gmd_pkg;

   localparam int GRAD_FIELD_W   = 16;
   localparam int MAG_W          = 16;
   localparam int CODE_W         = 6;
   localparam int DIMS_W         = 2;
   localparam int FIELD_AXES     = 3;

   localparam int DEF_MAX_DIMS   = 3;
   localparam int DEF_GRAD_WIDTH = 16;

   localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd2;

   // tan(pi/8) as a 40-bit fraction, split in two 20-bit halves
   localparam int                  TAN_SPLIT = 20;
   localparam logic [39:0]         TAN_FRAC  = 40'h6A09E667F4;
   localparam logic [TAN_SPLIT-1:0] TAN_HI   = TAN_FRAC[39:20];
   localparam logic [TAN_SPLIT-1:0] TAN_LO   = TAN_FRAC[19:0];

   typedef struct packed {
      logic signed [GRAD_FIELD_W-1:0] grad_first;
      logic signed [GRAD_FIELD_W-1:0] grad_second;
      logic signed [GRAD_FIELD_W-1:0] grad_third;
   } req_payload_type;

   typedef struct packed {
      logic [MAG_W-1:0]  magnitude;
      logic [CODE_W-1:0] direction_code;
   } rsp_payload_type;

endpackage

>>> hdl/gradient_magnitude_direction_unit.sv
// ----------------------------------------------------------------------------
// gradient_magnitude_direction_unit: gradient magnitude and direction code
// Per pixel: floor sqrt of the sum of squared components, plus strong-axis
// sign bits against a tan(pi/8) threshold of the largest component.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one pixel's gradient components per transfer (valid/stall).
//   rsp_*  : magnitude and direction code, one transfer per request.
//   csr_*  : write of dims_in_use (2 bits); csr_ready is always high.
//            Write only while the block holds no pending pixel.
// Throughput: one pixel per cycle while the skid is empty. Every stage holds one pixel;
//   the pipeline advances as a whole.
// Pipeline: two lane stages (abs, square), three merge stages (sum/max,
//   threshold products, compare), GRAD_WIDTH + 1 square root stages (one
//   root bit each), then one output register.
// Stall: the output register is backed by a one-entry skid buffer. A pixel
//   leaving the pipeline while the output is stalled goes into the skid; the
//   pipeline and req_stall then hold until the output drains. req_stall is
//   a registered signal.
// Reset: clears all valid flags (no result pending) and sets dims_in_use
//   to 2. No clearing pass; requests are taken in the first cycle after.
// ----------------------------------------------------------------------------
module gradient_magnitude_direction_unit #(
   parameter int MAX_DIMS   = gmd_pkg::DEF_MAX_DIMS,
   parameter int GRAD_WIDTH = gmd_pkg::DEF_GRAD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gmd_pkg::req_payload_type      req_data,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gmd_pkg::rsp_payload_type      rsp_data,
   // configuration write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gmd_pkg::DIMS_W-1:0]    csr_data
);
   import gmd_pkg::*;

   localparam int SW     = 2*GRAD_WIDTH + 2;   // sum of squares width
   localparam int RW     = SW / 2;             // root width
   localparam int PIPE_N = 5 + RW;             // lanes 2, merge 3, root RW

   // configuration
   logic [DIMS_W-1:0] dims_ff, dims_in;
   logic [DIMS_W-1:0] dims_eff;
   logic [MAX_DIMS-1:0] lane_used;

   // pipeline control: one shared advance, valid flag per stage
   logic              advance;
   logic [PIPE_N-1:0] pipe_v_ff, pipe_v_in;

   // output register and skid
   logic            out_v_ff, out_v_in;
   logic            skid_v_ff, skid_v_in;
   rsp_payload_type out_ff, out_in;
   rsp_payload_type skid_ff, skid_in;
   rsp_payload_type pipe_rsp;

   // lane datapath
   logic [GRAD_FIELD_W-1:0] grad_raw [FIELD_AXES];
   logic [GRAD_WIDTH-1:0]   lane_abs [MAX_DIMS];
   logic                    lane_neg [MAX_DIMS];
   logic [2*GRAD_WIDTH-1:0] lane_sq  [MAX_DIMS];

   logic [SW-1:0]      sum;
   logic [CODE_W-1:0]  merge_code;
   logic [RW-1:0]      root;
   logic [CODE_W-1:0]  root_code;
   logic [RW+MAG_W-1:0] root_ext;

   // the pipeline only stops once the skid is holding a result
   assign advance   = ~skid_v_ff;
   assign req_stall = skid_v_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   assign grad_raw[0] = $unsigned(req_data.grad_first);
   assign grad_raw[1] = $unsigned(req_data.grad_second);
   assign grad_raw[2] = $unsigned(req_data.grad_third);

   // axes beyond the configured count (clamped to MAX_DIMS) read as zero
   always_comb begin
      dims_eff = (dims_ff > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_ff;
      for (int a = 0; a < MAX_DIMS; a++) begin
         lane_used[a] = DIMS_W'(a) < dims_eff;
      end
   end

   for (genvar a = 0; a < MAX_DIMS; a++) begin : g_lane
      gmd_lane #(
         .GW (GRAD_WIDTH)
      ) u_lane (
         .clock    (clock),
         .advance  (advance),
         .used     (lane_used[a]),
         .grad_raw (grad_raw[a]),
         .abs_val  (lane_abs[a]),
         .neg      (lane_neg[a]),
         .square   (lane_sq[a])
      );
   end

   gmd_merge #(
      .LANES (MAX_DIMS),
      .GW    (GRAD_WIDTH)
   ) u_merge (
      .clock   (clock),
      .advance (advance),
      .abs_val (lane_abs),
      .neg     (lane_neg),
      .square  (lane_sq),
      .sum     (sum),
      .code    (merge_code)
   );

   gmd_isqrt #(
      .SW    (SW),
      .TAG_W (CODE_W)
   ) u_isqrt (
      .clock    (clock),
      .advance  (advance),
      .in_x     (sum),
      .in_tag   (merge_code),
      .out_root (root),
      .out_tag  (root_code)
   );

   // saturate the root to the 16-bit field (only bites for wide gradients)
   always_comb begin
      root_ext                = {{MAG_W{1'b0}}, root};
      pipe_rsp.direction_code = root_code;
      if (root_ext > (RW+MAG_W)'({MAG_W{1'b1}})) begin
         pipe_rsp.magnitude = '1;
      end else begin
         pipe_rsp.magnitude = root_ext[MAG_W-1:0];
      end
   end

   // next-state logic
   always_comb begin
      dims_in   = (csr_valid && csr_ready) ? csr_data : dims_ff;
      pipe_v_in = advance ? {pipe_v_ff[PIPE_N-2:0], req_valid} : pipe_v_ff;
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!out_v_ff || !rsp_stall) begin
         // output free: drain the skid first, else take the pipeline's end
         if (skid_v_ff) begin
            out_in    = skid_ff;
            out_v_in  = 1'b1;
            skid_v_in = 1'b0;
         end else begin
            out_in    = pipe_rsp;
            out_v_in  = advance & pipe_v_ff[PIPE_N-1];
         end
      end else if (advance && pipe_v_ff[PIPE_N-1]) begin
         // output stalled and a result arrives: park it
         skid_in   = pipe_rsp;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff   <= DIMS_RESET;
         pipe_v_ff <= '0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         dims_ff   <= dims_in;
         pipe_v_ff <= pipe_v_in;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

>>> hdl/gmd_lane.sv
// ----------------------------------------------------------------------------
// gmd_lane: one axis of the gradient datapath
// Sign and absolute value of one component, then its square (two stages).
// ----------------------------------------------------------------------------
module gmd_lane #(
   parameter int GW = gmd_pkg::DEF_GRAD_WIDTH
) (
   input  logic                            clock,
   input  logic                            advance,
   input  logic                            used,
   input  logic [gmd_pkg::GRAD_FIELD_W-1:0] grad_raw,
   output logic [GW-1:0]                   abs_val,
   output logic                            neg,
   output logic [2*GW-1:0]                 square
);
   import gmd_pkg::*;

   logic [GW+GRAD_FIELD_W-1:0] raw_ext;
   logic [GW-1:0]              comp;
   logic [GW-1:0]              abs1_ff, abs1_in;
   logic                       neg1_ff, neg1_in;
   logic [GW-1:0]              abs2_ff;
   logic                       neg2_ff;
   logic [2*GW-1:0]            sq2_ff, sq2_in;

   always_comb begin
      raw_ext = {{GW{1'b0}}, grad_raw};
      comp    = raw_ext[GW-1:0];
      neg1_in = used & comp[GW-1];
      if (!used) begin
         abs1_in = '0;
      end else if (comp[GW-1]) begin
         abs1_in = (~comp) + GW'(1);
      end else begin
         abs1_in = comp;
      end
      sq2_in = (2*GW)'(abs1_ff) * (2*GW)'(abs1_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abs1_ff <= abs1_in;
         neg1_ff <= neg1_in;
         abs2_ff <= abs1_ff;
         neg2_ff <= neg1_ff;
         sq2_ff  <= sq2_in;
      end
   end

   assign abs_val = abs2_ff;
   assign neg     = neg2_ff;
   assign square  = sq2_ff;

endmodule

>>> hdl/gmd_merge.sv
// ----------------------------------------------------------------------------
// gmd_merge: combines the lanes
// Sum of squares and largest magnitude, threshold products, direction code.
// ----------------------------------------------------------------------------
module gmd_merge #(
   parameter int LANES = gmd_pkg::DEF_MAX_DIMS,
   parameter int GW    = gmd_pkg::DEF_GRAD_WIDTH
) (
   input  logic                      clock,
   input  logic                      advance,
   input  logic [GW-1:0]             abs_val [LANES],
   input  logic                      neg     [LANES],
   input  logic [2*GW-1:0]           square  [LANES],
   output logic [2*GW+1:0]           sum,
   output logic [gmd_pkg::CODE_W-1:0] code
);
   import gmd_pkg::*;

   localparam int SW = 2*GW + 2;
   localparam int PW = GW + TAN_SPLIT;

   // stage: sum and maximum
   logic [SW-1:0] sum3_ff, sum3_in;
   logic [GW-1:0] max3_ff, max3_in;
   logic [GW-1:0] abs3_ff [LANES];
   logic          neg3_ff [LANES];
   // stage: max times tan(pi/8), in two halves
   logic [PW-1:0] hi4_ff, hi4_in;
   logic [PW-1:0] lo4_ff, lo4_in;
   logic [SW-1:0] sum4_ff;
   logic [GW-1:0] abs4_ff [LANES];
   logic          neg4_ff [LANES];
   // stage: compare and code
   logic [PW-1:0]     thresh;
   logic              above;
   logic [CODE_W-1:0] code5_ff, code5_in;
   logic [SW-1:0]     sum5_ff;

   always_comb begin
      sum3_in = '0;
      max3_in = '0;
      for (int a = 0; a < LANES; a++) begin
         sum3_in = sum3_in + SW'(square[a]);
         if (abs_val[a] > max3_in) begin
            max3_in = abs_val[a];
         end
      end
   end

   always_comb begin
      hi4_in = PW'(max3_ff) * PW'(TAN_HI);
      lo4_in = PW'(max3_ff) * PW'(TAN_LO);
   end

   // abs * 2^40 > TAN * max, evaluated exactly on the 20-bit split
   always_comb begin
      thresh   = hi4_ff + PW'(lo4_ff[PW-1:TAN_SPLIT]);
      above    = 1'b0;
      code5_in = '0;
      for (int a = 0; a < LANES; a++) begin
         above = {abs4_ff[a], {TAN_SPLIT{1'b0}}} > thresh;
         code5_in[2*a]   = above & ~neg4_ff[a];
         code5_in[2*a+1] = above &  neg4_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum3_ff  <= sum3_in;
         max3_ff  <= max3_in;
         abs3_ff  <= abs_val;
         neg3_ff  <= neg;
         hi4_ff   <= hi4_in;
         lo4_ff   <= lo4_in;
         sum4_ff  <= sum3_ff;
         abs4_ff  <= abs3_ff;
         neg4_ff  <= neg3_ff;
         code5_ff <= code5_in;
         sum5_ff  <= sum4_ff;
      end
   end

   assign sum  = sum5_ff;
   assign code = code5_ff;

endmodule

>>> hdl/gmd_isqrt.sv
// ----------------------------------------------------------------------------
// gmd_isqrt: pipelined floor square root
// One root bit per stage, restoring digit-by-digit method; tag rides along.
// ----------------------------------------------------------------------------
module gmd_isqrt #(
   parameter int SW    = 2*gmd_pkg::DEF_GRAD_WIDTH + 2,
   parameter int TAG_W = gmd_pkg::CODE_W
) (
   input  logic              clock,
   input  logic              advance,
   input  logic [SW-1:0]     in_x,
   input  logic [TAG_W-1:0]  in_tag,
   output logic [SW/2-1:0]   out_root,
   output logic [TAG_W-1:0]  out_tag
);
   localparam int RW    = SW / 2;
   localparam int REM_W = RW + 2;

   logic [SW-1:0]    x_ff    [RW];
   logic [SW-1:0]    x_in    [RW];
   logic [REM_W-1:0] rem_ff  [RW];
   logic [REM_W-1:0] rem_in  [RW];
   logic [RW-1:0]    root_ff [RW];
   logic [RW-1:0]    root_in [RW];
   logic [TAG_W-1:0] tag_ff  [RW];
   logic [TAG_W-1:0] tag_in  [RW];

   always_comb begin
      logic [SW-1:0]    xp;
      logic [REM_W-1:0] remp;
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] trial;
      logic [RW-1:0]    rootp;
      logic             ge;
      for (int k = 0; k < RW; k++) begin
         if (k == 0) begin
            xp        = in_x;
            remp      = '0;
            rootp     = '0;
            tag_in[k] = in_tag;
         end else begin
            xp        = x_ff[k-1];
            remp      = rem_ff[k-1];
            rootp     = root_ff[k-1];
            tag_in[k] = tag_ff[k-1];
         end
         shifted    = {remp[REM_W-3:0], xp[SW-1:SW-2]};
         trial      = {rootp, 2'b01};
         ge         = shifted >= trial;
         rem_in[k]  = ge ? (shifted - trial) : shifted;
         root_in[k] = {rootp[RW-2:0], ge};
         x_in[k]    = {xp[SW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         tag_ff  <= tag_in;
      end
   end

   assign out_root = root_ff[RW-1];
   assign out_tag  = tag_ff[RW-1];

endmodule

>>> bench/gradient_magnitude_direction_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_magnitude_direction_unit_tb: self-checking bench for the unit
// Drives pixels of signed gradient components over the request channel.
// A local predictor computes floor-root magnitude and strong-axis code for
// each transfer. Every response is matched in order against that prediction.
// Covers all dimension counts, random idling on both sides and a long
// output hold that fills the pipeline.
// ----------------------------------------------------------------------------
module gradient_magnitude_direction_unit_tb;
   import gmd_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 12;
   localparam int LONG_HOLD     = 400;      // receiver hold, in cycles
   localparam int DRAIN_TAIL    = 30;       // tail after the last drain, in cycles
   localparam int REPORT_LIMIT  = 10;
   localparam int WATCHDOG_NS   = 5_000_000;

   // ------------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // ------------------------------------------------------------------------
   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_payload_type     req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_payload_type     rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [DIMS_W-1:0]   csr_data  = '0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   gradient_magnitude_direction_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   rsp_payload_type     awaited_gradients [$];   // predicted, oldest first
   rsp_payload_type     oldest_gradient;
   logic [DIMS_W-1:0]   dims_setting = DIMS_RESET; // local copy of dims_in_use
   bit   [3:0]          dims_visited = '0;
   bit                  sender_idling   = 1'b0;
   bit                  receiver_idling = 1'b0;
   int                  receiver_hold   = 0;      // long hold request, in cycles
   int                  pixels_sent       = 0;
   int                  gradients_compared = 0;
   int                  field_mismatches  = 0;

   // ------------------------------------------------------------------------
   // Predictor: magnitude is floor(sqrt(sum of squares)) over the used axes;
   // each used axis whose absolute value is strictly above tan(pi/8) times
   // the largest one sets its sign bit in the code. The threshold compare is
   // exact: abs * 2^40 > TAN_FRAC * peak.
   // ------------------------------------------------------------------------
   function automatic rsp_payload_type gradient_response_of(
      input req_payload_type px, input logic [DIMS_W-1:0] dims);
      logic [GRAD_FIELD_W-1:0] comp [FIELD_AXES];
      logic [GRAD_FIELD_W:0]   mag_abs [FIELD_AXES];
      logic [GRAD_FIELD_W:0]   wide;
      logic [GRAD_FIELD_W:0]   peak;
      logic [GRAD_FIELD_W:0]   root;
      logic [GRAD_FIELD_W:0]   trial;
      logic [63:0]             sq_sum;
      logic [CODE_W-1:0]       code;
      int                      used;
      rsp_payload_type         r;

      comp[0] = px.grad_first;
      comp[1] = px.grad_second;
      comp[2] = px.grad_third;
      used    = (int'(dims) > DEF_MAX_DIMS) ? DEF_MAX_DIMS : int'(dims);
      sq_sum  = '0;
      peak    = '0;
      code    = '0;
      for (int a = 0; a < FIELD_AXES; a++) begin
         mag_abs[a] = '0;
      end
      for (int a = 0; a < used; a++) begin
         wide = {comp[a][GRAD_FIELD_W-1], comp[a]};
         // exact absolute value, so -32768 becomes 32768
         mag_abs[a] = comp[a][GRAD_FIELD_W-1] ? (~wide + 1'b1) : wide;
         sq_sum += 64'(mag_abs[a]) * 64'(mag_abs[a]);
         if (mag_abs[a] > peak) begin
            peak = mag_abs[a];
         end
      end

      // root built one bit at a time from the top
      root = '0;
      for (int b = GRAD_FIELD_W; b >= 0; b--) begin
         trial = root | ((GRAD_FIELD_W + 1)'(1) << b);
         if (64'(trial) * 64'(trial) <= sq_sum) begin
            root = trial;
         end
      end
      r.magnitude = root[GRAD_FIELD_W] ? {MAG_W{1'b1}} : root[MAG_W-1:0];

      if (peak != 0) begin
         for (int a = 0; a < used; a++) begin
            if (mag_abs[a] != 0 &&
                (64'(mag_abs[a]) << 40) > 64'(TAN_FRAC) * 64'(peak)) begin
               code[2 * a + (comp[a][GRAD_FIELD_W-1] ? 1 : 0)] = 1'b1;
            end
         end
      end
      r.direction_code = code;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic req_payload_type pixel(input int first, input int second,
                                             input int third);
      req_payload_type px;
      px.grad_first  = 16'(first);
      px.grad_second = 16'(second);
      px.grad_third  = 16'(third);
      return px;
   endfunction

   // Mix of plain random, small, extreme, near-threshold and tied pixels.
   function automatic req_payload_type random_pixel();
      logic [GRAD_FIELD_W-1:0] comp [FIELD_AXES];
      int                      style;
      int                      peak;
      int                      near;
      int                      peak_ax;
      int                      near_ax;

      style = $urandom_range(0, 5);
      for (int a = 0; a < FIELD_AXES; a++) begin
         case (style)
            0, 1: comp[a] = 16'($urandom);
            2: begin
               comp[a] = 16'($urandom_range(0, 15));
               if (comp[a][3]) begin
                  comp[a] = comp[a] | 16'hFFF0;
               end
            end
            3: begin
               case ($urandom_range(0, 4))
                  0:       comp[a] = 16'h8000;
                  1:       comp[a] = 16'h7FFF;
                  2:       comp[a] = 16'h0000;
                  3:       comp[a] = 16'hFFFF;
                  default: comp[a] = 16'h0001;
               endcase
            end
            default: comp[a] = 16'($urandom_range(0, 511)) - 16'd256;
         endcase
      end
      // near-threshold pairs (tan(pi/8) ~ 27146/65536) and exact ties
      if (style >= 4) begin
         peak = $urandom_range(1, 32768);
         near = (style == 4) ? ((peak * 27146) >>> 16) + $urandom_range(0, 4) - 2 : peak;
         if (near < 0) begin
            near = 0;
         end
         if (near > peak) begin
            near = peak;
         end
         peak_ax = $urandom_range(0, 2);
         near_ax = (peak_ax + $urandom_range(1, 2)) % FIELD_AXES;
         comp[peak_ax] = (peak == 32768 || $urandom_range(0, 1) == 1) ?
                         16'(-peak) : 16'(peak);
         comp[near_ax] = ($urandom_range(0, 1) == 1) ? 16'(-near) : 16'(near);
      end
      return pixel(int'($signed(comp[0])), int'($signed(comp[1])),
                   int'($signed(comp[2])));
   endfunction

   // One request transfer; the prediction is queued at the accepting edge.
   // Valid is left high so back-to-back transfers need no extra edge.
   task automatic send_pixel(input req_payload_type px);
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      awaited_gradients.insert(awaited_gradients.size(),
                               gradient_response_of(px, dims_setting));
      pixels_sent++;
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Sender pause: stop offering and wait until every response is back.
   // Always waits on the clock first, so valid is never lowered and raised
   // in the same step.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_gradients.size() != 0);
   endtask

   // dims_in_use write; only ever issued with the unit drained.
   task automatic write_dims(input logic [DIMS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      dims_setting  = value;
      dims_visited[value] = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stall bursts, or a long hold when one is requested
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (receiver_hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (receiver_hold) @(posedge clock);
            receiver_hold = 0;
            rsp_stall    <= 1'b0;
         end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response checking: every response transfer against the oldest prediction
   // ------------------------------------------------------------------------
   task automatic note_mismatch(input string what, input int want, input int got);
      field_mismatches++;
      if (field_mismatches <= REPORT_LIMIT) begin
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_gradients.size() == 0) begin
            note_mismatch("unexpected response magnitude", -1, int'(rsp_data.magnitude));
         end else begin
            oldest_gradient = awaited_gradients.pop_front();
            gradients_compared++;
            if (rsp_data.magnitude !== oldest_gradient.magnitude) begin
               note_mismatch("magnitude", int'(oldest_gradient.magnitude),
                             int'(rsp_data.magnitude));
            end
            if (rsp_data.direction_code !== oldest_gradient.direction_code) begin
               note_mismatch("direction_code", int'(oldest_gradient.direction_code),
                             int'(rsp_data.direction_code));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset value of dims_in_use is two: third axis must be ignored.
   task automatic test_reset_dims();
      dims_visited[DIMS_RESET] = 1'b1;
      send_pixel(pixel(3, 4, 100));
      send_pixel(pixel(-32768, -32768, -32768));
      send_pixel(pixel(0, 0, 7));
   endtask

   // Field extremes, all-zero pixel, threshold edges and ties with all axes.
   task automatic test_directed_three_axes();
      wait_for_drain();
      write_dims(2'd3);
      send_pixel(pixel(0, 0, 0));
      send_pixel(pixel(32767, 32767, 32767));
      send_pixel(pixel(-32768, -32768, -32768));
      send_pixel(pixel(-32768, 0, 0));
      send_pixel(pixel(0, 32767, 0));
      send_pixel(pixel(0, 0, -1));
      send_pixel(pixel(1, 0, 0));
      send_pixel(pixel(1000, 414, 0));      // just under tan(pi/8)
      send_pixel(pixel(1000, 415, 0));      // just over
      send_pixel(pixel(-32768, 13573, -13574));
      send_pixel(pixel(-500, 500, 500));    // three-way tie
      send_pixel(pixel(5, -5, 0));
      send_pixel(pixel(-1, 1, -1));
      send_pixel(pixel(-32768, 32767, 0));
   endtask

   // One axis in use, then none: the zero count gives zero magnitude and code.
   task automatic test_directed_few_axes();
      wait_for_drain();
      write_dims(2'd1);
      send_pixel(pixel(-7, 32767, -32768));
      send_pixel(pixel(32767, 5, 5));
      send_pixel(pixel(0, 9, 9));
      wait_for_drain();
      write_dims(2'd0);
      send_pixel(pixel(-32768, 32767, 1));
      send_pixel(pixel(0, 0, 0));
      send_pixel(pixel(123, -45, 6));
   endtask

   // Random phases over every dims setting, idling switched per phase.
   task automatic test_random_sweep();
      logic [DIMS_W-1:0] order [4];
      logic [DIMS_W-1:0] next_dims;
      order = '{2'd3, 2'd0, 2'd1, 2'd2};
      for (int ph = 0; ph < 8; ph++) begin
         next_dims = (ph < 4) ? order[ph] : 2'($urandom_range(0, 3));
         wait_for_drain();
         write_dims(next_dims);
         sender_idling   = ($urandom_range(0, 3) != 0);
         receiver_idling = ($urandom_range(0, 3) != 0);
         repeat (150) send_pixel(random_pixel());
      end
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering:
   // the pipeline and skid fill and req_stall must hold the input back.
   task automatic test_output_hold();
      wait_for_drain();
      write_dims(2'd3);
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      receiver_hold   = LONG_HOLD;
      repeat (120) send_pixel(random_pixel());
   endtask

   // Bursts separated by full drains, without a register write in between.
   task automatic test_sender_pauses();
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      for (int burst = 0; burst < 3; burst++) begin
         wait_for_drain();
         repeat (20) send_pixel(random_pixel());
      end
   endtask

   // Closing stretch at full rate, no idling on either side.
   task automatic test_full_rate();
      wait_for_drain();
      write_dims(2'd3);
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      repeat (200) send_pixel(random_pixel());
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_dims();
      test_directed_three_axes();
      test_directed_few_axes();
      test_random_sweep();
      test_output_hold();
      test_sender_pauses();
      test_full_rate();

      // everything back, then a tail to catch stray responses
      wait_for_drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      field_mismatches += awaited_gradients.size();

      $display("Sent %0d pixels, compared %0d responses, %0d failures.",
               pixels_sent, gradients_compared, field_mismatches);
      $display("Dims settings exercised %b (bit per count); long output hold %0d cycles.",
               dims_visited, LONG_HOLD);
      if (field_mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #(WATCHDOG_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
hdl/gmd_pkg.sv
hdl/gmd_lane.sv
hdl/gmd_merge.sv
hdl/gmd_isqrt.sv
hdl/gradient_magnitude_direction_unit.sv
bench/gradient_magnitude_direction_unit_tb.sv
